FILE: rtl/ffg_pkg.sv
// ----------------------------------------------------------------------------
// ffg_pkg
// Shared constants, types and tables for the fog factor table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffg_pkg;

  localparam int TABLE_ENTRIES        = 33;
  localparam int FACTOR_FRACTION_BITS = 16;
  localparam int DEPTH_EXP_CAP        = 40;

  // largest depth exponent that can reach the datapath
  localparam int I_MAX = (TABLE_ENTRIES - 1 < DEPTH_EXP_CAP) ? TABLE_ENTRIES - 1
                                                               : DEPTH_EXP_CAP;
  localparam int IW     = $clog2(I_MAX + 1);
  localparam int LIN_W  = ((I_MAX + 17 > 48) ? I_MAX + 17 : 48) + 1;
  localparam int XW     = 24 + I_MAX;
  localparam int FACT_W = FACTOR_FRACTION_BITS + 1;

  localparam logic [FACT_W-1:0] FACTOR_ONE = FACT_W'(1) << FACTOR_FRACTION_BITS;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  localparam int TAYLOR_TERMS = 13;
  localparam int K_W          = 4;

  // pipeline: 6 front stages, 3 per series term, then the output register
  localparam int LAST_STAGE = 6 + 3 * TAYLOR_TERMS;
  localparam int QD_LEN     = LAST_STAGE - 4 - FACTOR_FRACTION_BITS;

  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_EXP    = 2'd1,
    MODE_EXP2   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MODE    = 2'd0,
    CFG_START   = 2'd1,
    CFG_END     = 2'd2,
    CFG_DENSITY = 2'd3
  } cfg_idx_e;

  // side band that rides along with each beat
  typedef struct packed {
    mode_e mode;
    logic  big;    // exp argument past the cutoff
    logic  fault;  // linear with end == start
    logic  zero;   // linear quotient is zero or negative
    logic  one;    // linear quotient saturates
  } sb_t;

  typedef struct packed {
    logic [47:0]                     r;
    logic [47:0]                     ad;
    logic [FACTOR_FRACTION_BITS-1:0] q;
  } div_t;

  typedef struct packed {
    logic [32:0] term;
    logic [33:0] sum;
    logic [31:0] r;
    logic [7:0]  n;
  } tay_t;

  // floor(2^32 / k) for the series divisors
  function automatic logic [32:0] recip(input logic [K_W-1:0] k);
    logic [32:0] m;
    case (k)
      4'd1:    m = 33'd4294967296;
      4'd2:    m = 33'd2147483648;
      4'd3:    m = 33'd1431655765;
      4'd4:    m = 33'd1073741824;
      4'd5:    m = 33'd858993459;
      4'd6:    m = 33'd715827882;
      4'd7:    m = 33'd613566756;
      4'd8:    m = 33'd536870912;
      4'd9:    m = 33'd477218588;
      4'd10:   m = 33'd429496729;
      4'd11:   m = 33'd390451572;
      4'd12:   m = 33'd357913941;
      4'd13:   m = 33'd330382099;
      default: m = 33'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ffg_div_cell.sv
// ----------------------------------------------------------------------------
// ffg_div_cell
// One restoring division step: shift, trial subtract, one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ffg_div_cell (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire ffg_pkg::div_t in_i,
  output ffg_pkg::div_t     out_o
);
  import ffg_pkg::*;

  div_t        out_d, out_q;
  logic [48:0] r2;
  logic        ge;

  always_comb begin
    r2        = {in_i.r, 1'b0};
    ge        = r2 >= {1'b0, in_i.ad};
    out_d.ad  = in_i.ad;
    out_d.r   = ge ? 48'(r2 - {1'b0, in_i.ad}) : r2[47:0];
    out_d.q   = {in_i.q[FACTOR_FRACTION_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/ffg_taylor_cell.sv
// ----------------------------------------------------------------------------
// ffg_taylor_cell
// One series term of exp(-r): term*r, divide by k, subtract from the running sum for odd k, else add.
// ----------------------------------------------------------------------------
`default_nettype none

module ffg_taylor_cell (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [3:0]         k_i,
  input  wire ffg_pkg::tay_t      in_i,
  output ffg_pkg::tay_t           out_o
);
  import ffg_pkg::*;

  // stage a: product
  logic [31:0] prod_a_q;
  logic [33:0] sum_a_q;
  logic [31:0] r_a_q;
  logic [7:0]  n_a_q;
  logic [64:0] prod_full;
  // stage b: reciprocal product
  logic [64:0] m_b_q;
  logic [31:0] prod_b_q;
  logic [33:0] sum_b_q;
  logic [31:0] r_b_q;
  logic [7:0]  n_b_q;
  logic [64:0] m_d;
  // stage c: corrected quotient
  tay_t        out_d, out_q;
  logic [31:0] q0;
  logic [35:0] rem;
  logic [31:0] q;

  assign prod_full = 65'(in_i.term) * 65'(in_i.r);
  assign m_d       = 65'(prod_a_q) * 65'(recip(k_i));

  always_comb begin
    q0        = m_b_q[63:32];
    rem       = 36'(prod_b_q) - 36'(q0) * 36'(k_i);
    // estimate is at most one low
    q         = (rem >= 36'(k_i)) ? q0 + 32'd1 : q0;
    out_d.term = 33'(q);
    out_d.sum  = k_i[0] ? sum_b_q - 34'(q) : sum_b_q + 34'(q);
    out_d.r    = r_b_q;
    out_d.n    = n_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_a_q <= prod_full[63:32];
      sum_a_q  <= in_i.sum;
      r_a_q    <= in_i.r;
      n_a_q    <= in_i.n;
      m_b_q    <= m_d;
      prod_b_q <= prod_a_q;
      sum_b_q  <= sum_a_q;
      r_b_q    <= r_a_q;
      n_b_q    <= n_a_q;
      out_q    <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/fog_factor_table_generator.sv
// ----------------------------------------------------------------------------
// fog_factor_table_generator
// Fog factor at depth 2^index: linear, exp, exp squared or none, Q1.16 out.
// ----------------------------------------------------------------------------
// Pipeline: 6 front stages, 3 per series term over 13 terms, output register.
// Throughput: one beat per cycle; the whole pipeline holds only while the
//   output register is full and not taken.
// Reset: clears every stage valid and loads the register defaults
//   (linear, start 0, end 1.0, density 1.0).
`default_nettype none

module fog_factor_table_generator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [47:0]                   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [5:0]                    table_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ffg_pkg::FACT_W-1:0]         fog_factor_o,
  output logic                               divide_fault_o
);
  import ffg_pkg::*;

  // configuration
  mode_e        mode_q;
  logic [47:0]  start_q, end_q;
  logic [23:0]  density_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_LINEAR;
      start_q   <= 48'd0;
      end_q     <= 48'd65536;
      density_q <= 24'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:    mode_q    <= mode_e'(cfg_data_i[1:0]);
        CFG_START:   start_q   <= cfg_data_i;
        CFG_END:     end_q     <= cfg_data_i;
        CFG_DENSITY: density_q <= cfg_data_i[23:0];
        default:     ;
      endcase
    end
  end

  logic en;
  logic [LAST_STAGE:0] vld_q;

  assign en = !vld_q[LAST_STAGE] || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST_STAGE-1:0], in_valid_i};
    end
  end

  // stage 0: index clamp
  logic [6:0]    idx_ext, idx_sat;
  logic [IW-1:0] i_d, i_q;
  mode_e         mode0_q;

  always_comb begin
    idx_ext = {1'b0, table_index_i};
    idx_sat = (idx_ext >= 7'(TABLE_ENTRIES)) ? 7'(TABLE_ENTRIES - 1) : idx_ext;
    i_d     = (idx_sat > 7'(I_MAX)) ? IW'(I_MAX) : idx_sat[IW-1:0];
  end

  // stage 1: numerator, denominator, scaled density
  logic signed [LIN_W-1:0] num_d, num1_q;
  logic signed [48:0]      den_d, den1_q;
  logic [XW-1:0]           x_full;
  logic [20:0]             x1_q;
  sb_t                     sb_q [1:LAST_STAGE-1];
  sb_t                     sb1_d;

  always_comb begin
    num_d = $signed({{(LIN_W-48){end_q[47]}}, end_q})
          - $signed(LIN_W'(1) << (8'(i_q) + 8'd16));
    den_d = $signed({end_q[47], end_q}) - $signed({start_q[47], start_q});
    x_full = XW'(density_q) << i_q;
    sb1_d       = '0;
    sb1_d.mode  = mode0_q;
    sb1_d.big   = (mode0_q == MODE_EXP) ? (x_full >= XW'(32'h0020_0000))
                                        : (x_full >= XW'(32'd393216));
  end

  // stage 2: magnitudes, linear flags, exp argument
  logic [LIN_W-1:0] an2_q;
  logic [47:0]      ad2_q;
  logic [48:0]      den_abs;
  logic [37:0]      t_d, t2_q;
  sb_t              sb2_d;

  always_comb begin
    den_abs     = den1_q[48] ? 49'(-den1_q) : 49'(den1_q);
    sb2_d       = sb_q[1];
    sb2_d.fault = den1_q == 49'sd0;
    sb2_d.zero  = (num1_q == '0) || (num1_q[LIN_W-1] != den1_q[48]);
    t_d = (sb_q[1].mode == MODE_EXP) ? {1'b0, x1_q, 16'd0}
                                     : 38'(x1_q[18:0]) * 38'(x1_q[18:0]);
  end

  // stage 3: saturation check, divider load, log2(e) product
  div_t        dv [0:FACTOR_FRACTION_BITS];
  div_t        dv0_q;
  sb_t         sb3_d;
  logic [62:0] p3_q;
  logic [5:0]  th3_q;

  always_comb begin
    sb3_d     = sb_q[2];
    sb3_d.one = an2_q >= LIN_W'(ad2_q);
  end

  // stage 4: exponent split; stage 5: reduced argument
  logic [39:0] u_d;
  logic [7:0]  n4_q;
  logic [31:0] frac4_q;
  logic [63:0] r_full;
  tay_t        ty [0:TAYLOR_TERMS];
  tay_t        ty0_q;

  assign u_d    = ((40'(th3_q) * 40'(LOG2E_Q30)) << 2) + 40'(p3_q >> 30);
  assign r_full = 64'(frac4_q) * 64'(LN2_Q32);

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_q       <= i_d;
      mode0_q   <= mode_q;
      num1_q    <= num_d;
      den1_q    <= den_d;
      x1_q      <= x_full[20:0];
      sb_q[1]   <= sb1_d;
      an2_q     <= num1_q[LIN_W-1] ? LIN_W'(-num1_q) : LIN_W'(num1_q);
      ad2_q     <= den_abs[47:0];
      t2_q      <= t_d;
      sb_q[2]   <= sb2_d;
      sb_q[3]   <= sb3_d;
      dv0_q.r   <= an2_q[47:0];
      dv0_q.ad  <= ad2_q;
      dv0_q.q   <= '0;
      p3_q      <= 63'(t2_q[31:0]) * 63'(LOG2E_Q30);
      th3_q     <= t2_q[37:32];
      n4_q      <= u_d[39:32];
      frac4_q   <= u_d[31:0];
      ty0_q.term <= 33'h1_0000_0000;
      ty0_q.sum  <= 34'h1_0000_0000;
      ty0_q.r    <= r_full[63:32];
      ty0_q.n    <= n4_q;
      for (int j = 4; j < LAST_STAGE; j++) begin
        sb_q[j] <= sb_q[j-1];
      end
    end
  end

  assign dv[0] = dv0_q;
  assign ty[0] = ty0_q;

  for (genvar g = 0; g < FACTOR_FRACTION_BITS; g++) begin : g_div
    ffg_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .in_i  (dv[g]),
      .out_o (dv[g+1])
    );
  end

  for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_tay
    ffg_taylor_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .k_i   (K_W'(g + 1)),
      .in_i  (ty[g]),
      .out_o (ty[g+1])
    );
  end

  // linear quotient waits for the exp path
  logic [FACTOR_FRACTION_BITS-1:0] qd_q [0:QD_LEN-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      qd_q[0] <= dv[FACTOR_FRACTION_BITS].q;
      for (int j = 1; j < QD_LEN; j++) begin
        qd_q[j] <= qd_q[j-1];
      end
    end
  end

  // output stage: rounding and mode select
  sb_t              sbl;
  tay_t             tyl;
  logic [8:0]       sh;
  logic [34:0]      rsum, v;
  logic [FACT_W-1:0] exp_f, fac_d, fac_q;
  logic             fault_d, fault_q;

  always_comb begin
    sbl  = sb_q[LAST_STAGE-1];
    tyl  = ty[TAYLOR_TERMS];
    sh   = 9'(tyl.n) + 9'(32 - FACTOR_FRACTION_BITS);
    rsum = 35'(tyl.sum) + (35'(1) << (sh - 9'd1));
    v    = rsum >> sh;
    if (sh >= 9'd35) begin
      exp_f = '0;
    end else if (v > 35'(FACTOR_ONE)) begin
      exp_f = FACTOR_ONE;
    end else begin
      exp_f = v[FACT_W-1:0];
    end
    fault_d = 1'b0;
    case (sbl.mode)
      MODE_LINEAR: begin
        if (sbl.fault) begin
          fac_d   = FACTOR_ONE;
          fault_d = 1'b1;
        end else if (sbl.zero) begin
          fac_d = '0;
        end else if (sbl.one) begin
          fac_d = FACTOR_ONE;
        end else begin
          fac_d = FACT_W'(qd_q[QD_LEN-1]);
        end
      end
      MODE_EXP, MODE_EXP2: fac_d = sbl.big ? '0 : exp_f;
      default:             fac_d = FACTOR_ONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fac_q   <= fac_d;
      fault_q <= fault_d;
    end
  end

  assign in_ready_o     = en;
  assign out_valid_o    = vld_q[LAST_STAGE];
  assign fog_factor_o   = fac_q;
  assign divide_fault_o = fault_q;

endmodule

`default_nettype wire

FILE: rtl/ffg_checker.sv
// ----------------------------------------------------------------------------
// ffg_checker
// Port-level checks for the fog factor table generator.
// ----------------------------------------------------------------------------
`default_nettype none

module ffg_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      cfg_we_i,
  input wire logic [1:0]                cfg_idx_i,
  input wire logic [47:0]               cfg_data_i,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic [5:0]                table_index_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [ffg_pkg::FACT_W-1:0] fog_factor_o,
  input wire logic                      divide_fault_o
);
  import ffg_pkg::*;

  // a pending result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fog_factor_o)
      && $stable(divide_fault_o))
    else $error("output beat changed while stalled");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fog_factor_o <= FACTOR_ONE)
    else $error("fog factor above one");

  a_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |-> fog_factor_o == FACTOR_ONE)
    else $error("divide fault without unit factor");

endmodule

bind fog_factor_table_generator ffg_checker u_ffg_checker (.*);

`default_nettype wire

FILE: dv/fog_factor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fog_factor_checker
// Watches the register port and both channels of the fog factor generator,
// computes the factor for every accepted index and compares each output beat
// with the oldest pending expectation.
// ----------------------------------------------------------------------------
module fog_factor_checker
  import ffg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [47:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [5:0]        table_index_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [FACT_W-1:0] fog_factor_i,
  input  logic              divide_fault_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct {
    logic [FACT_W-1:0] factor;
    logic              fault;
  } fog_beat_t;

  mode_e             mode_q;
  longint            start_q;
  longint            end_q;
  logic [23:0]       density_q;
  fog_beat_t         factor_q[$];

  function automatic logic [FACT_W-1:0] linear_ramp(int unsigned i, output logic fault);
    longint          z, num, den;
    longint unsigned an, ad, rem, q;
    fault = 1'b0;
    z   = longint'(64'd1 << (i + 16));
    num = end_q - z;
    den = end_q - start_q;
    if (den == 0) begin
      fault = 1'b1;
      return FACTOR_ONE;
    end
    if (num == 0) return '0;
    if ((num < 0) != (den < 0)) return '0;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (an >= ad) return FACTOR_ONE;
    rem = an;
    q   = 0;
    for (int k = 0; k < FACTOR_FRACTION_BITS; k++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= ad) begin
        rem = rem - ad;
        q   = q | 1;
      end
    end
    return q[FACT_W-1:0];
  endfunction

  // exp(-t), t in Q.32: split into 2^-n times a short series on the ln2 remainder
  function automatic logic [FACT_W-1:0] exp_decay(longint unsigned t);
    longint unsigned th, tl, u, n, r, term, sum, s, v;
    th   = t >> 32;
    tl   = t & 64'hFFFF_FFFF;
    u    = ((th * 64'(LOG2E_Q30)) << 2) + ((tl * 64'(LOG2E_Q30)) >> 30);
    n    = u >> 32;
    r    = ((u & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32;
    term = 64'd1 << 32;
    sum  = term;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * r) >> 32) / k;
      if (k % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    s = n + 32 - FACTOR_FRACTION_BITS;
    if (s >= 63) return '0;
    v = (sum + (64'd1 << (s - 1))) >> s;
    return (v > FACTOR_ONE) ? FACTOR_ONE : v[FACT_W-1:0];
  endfunction

  function automatic fog_beat_t fog_at_depth(logic [5:0] idx);
    fog_beat_t       b;
    int unsigned     i;
    longint unsigned x;
    i = (idx >= TABLE_ENTRIES) ? TABLE_ENTRIES - 1 : idx;
    x = 64'(density_q) << i;
    b.fault = 1'b0;
    case (mode_q)
      MODE_LINEAR: b.factor = linear_ramp(i, b.fault);
      MODE_EXP:    b.factor = (x >= (64'd32 << 16)) ? '0 : exp_decay(x << 16);
      MODE_EXP2:   b.factor = (x >= (64'd6 << 16)) ? '0 : exp_decay(x * x);
      default:     b.factor = FACTOR_ONE;
    endcase
    return b;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fog_beat_t exp_b;
    int        errs;
    errs = 0;
    if (!rst_ni) begin
      mode_q       <= MODE_LINEAR;
      start_q      <= 0;
      end_q        <= 65536;
      density_q    <= 24'd65536;
      fail_count_o <= 0;
      pending_o    <= 0;
      factor_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MODE:    mode_q    <= mode_e'(cfg_data_i[1:0]);
          CFG_START:   start_q   <= longint'(signed'(cfg_data_i));
          CFG_END:     end_q     <= longint'(signed'(cfg_data_i));
          CFG_DENSITY: density_q <= cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) factor_q.push_back(fog_at_depth(table_index_i));
      if (out_valid_i && out_ready_i) begin
        if (factor_q.size() == 0) begin
          $error("output beat with nothing expected: fog_factor %0d divide_fault %0d",
                 fog_factor_i, divide_fault_i);
          errs++;
        end else begin
          exp_b = factor_q.pop_front();
          if (exp_b.factor !== fog_factor_i) begin
            $error("fog_factor: expected %0d, got %0d", exp_b.factor, fog_factor_i);
            errs++;
          end
          if (exp_b.fault !== divide_fault_i) begin
            $error("divide_fault: expected %0d, got %0d", exp_b.fault, divide_fault_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= factor_q.size();
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Fog factor generator testbench: steps through register settings, sends
// table indexes under random gaps and output stalls, and lets the checker
// judge every output beat.
// ----------------------------------------------------------------------------
module tb;
  import ffg_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 40;
  localparam int PER_PHASE   = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = '0;
  logic [47:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [5:0]        table_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [FACT_W-1:0] fog_factor_o;
  logic              divide_fault_o;
  int                fail_count;
  int                pending;

  bit                quiet = 1'b0;
  int unsigned       stall_odds = 4;
  int                stall_left = 0;
  int                idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  fog_factor_table_generator i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .table_index_i,
    .out_valid_o, .out_ready_i, .fog_factor_o, .divide_fault_o
  );

  fog_factor_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .table_index_i,
    .out_valid_i(out_valid_o), .out_ready_i, .fog_factor_i(fog_factor_o),
    .divide_fault_i(divide_fault_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // output stalls in short bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic load_regs(logic [1:0] mode, logic [47:0] start_v, logic [47:0] end_v,
                           logic [23:0] dens);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MODE;    cfg_data_i <= 48'(mode);  @(posedge clk_i);
    cfg_idx_i <= CFG_START;   cfg_data_i <= start_v;    @(posedge clk_i);
    cfg_idx_i <= CFG_END;     cfg_data_i <= end_v;      @(posedge clk_i);
    cfg_idx_i <= CFG_DENSITY; cfg_data_i <= 48'(dens);  @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_index(logic [5:0] idx);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    table_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [5:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return 6'($urandom_range(0, 63));
      1:       return 6'($urandom_range(0, 4));
      default: return 6'($urandom_range(0, 32));
    endcase
  endfunction

  // signed depth near 2^k, so the linear ramp crosses the sample depths
  function automatic logic [47:0] pick_depth();
    longint v;
    v = longint'($urandom_range(1, 65535)) << $urandom_range(0, 31);
    if ($urandom_range(0, 3) == 0) v = -v;
    if ($urandom_range(0, 9) == 0) v = longint'({$urandom, $urandom});
    return v[47:0];
  endfunction

  function automatic logic [23:0] pick_density();
    case ($urandom_range(0, 3))
      0:       return 24'($urandom);
      1:       return 24'($urandom_range(0, 255));
      default: return 24'($urandom_range(1, 65535)) >> $urandom_range(0, 12);
    endcase
  endfunction

  initial begin
    logic [47:0] s, e;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults, then the extremes of every register and mode
    send_index(6'd0); send_index(6'd1); send_index(6'd32);
    send_index(6'd33); send_index(6'd63);
    drain();
    load_regs(MODE_LINEAR, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, '0);
    send_index(6'd0); send_index(6'd31); send_index(6'd32);
    drain();
    load_regs(MODE_LINEAR, 48'h0000_0004_0000, 48'h0000_0004_0000, '0);
    send_index(6'd2); send_index(6'd42);
    drain();
    load_regs(MODE_LINEAR, 48'h0000_0010_0000, 48'h0000_0001_0000, 24'hFF_FFFF);
    send_index(6'd0); send_index(6'd3); send_index(6'd5);
    drain();
    load_regs(MODE_EXP, '0, '0, 24'hFF_FFFF);
    send_index(6'd0); send_index(6'd21);
    drain();
    load_regs(MODE_EXP, '0, '0, '0);
    send_index(6'd0); send_index(6'd63);
    drain();
    load_regs(MODE_EXP2, '0, '0, 24'h00_0001);
    send_index(6'd0); send_index(6'd18); send_index(6'd32);
    drain();
    load_regs(MODE_NONE, 48'h0000_0001_0000, 48'h0000_0001_0000, 24'h01_0000);
    send_index(6'd7); send_index(6'd63);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      quiet = (p >= PHASES - 4);
      stall_odds = $urandom_range(0, 6);
      s = pick_depth();
      e = ($urandom_range(0, 7) == 0) ? s : pick_depth();
      load_regs(2'($urandom_range(0, 3)), s, e, pick_density());
      for (int n = 0; n < PER_PHASE; n++) send_index(pick_index());
      drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
